>>> hw/rtl/cel_pkg.sv
// package with request, result and control types for the compacting element list
`timescale 1ns / 1ps

package cel_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_RM_IDX = 2'd2,
    OP_RM_VAL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MATCH = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    op_t         func;
    logic [31:0] value;
    logic [5:0]  index;
  } req_t;

  typedef struct packed {
    stat_t       status;
    logic [31:0] data;
    logic [6:0]  count;
  } rsp_t;

  typedef struct packed {
    op_t  op;
    logic match;
    logic exec;
  } cell_ctl_t;

endpackage

>>> hw/rtl/cel_cell.sv
// one storage cell of the list: holds an element, flags a match, shifts from its right neighbor
`timescale 1ns / 1ps

module cel_cell import cel_pkg::*; #(
  parameter int ELEMENT_BITS = 32,
  parameter int IW           = 7,
  parameter int POS          = 0
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [ELEMENT_BITS-1:0] key,
  input  logic [IW-1:0]           idx,
  input  logic [IW-1:0]           cnt,
  input  logic [ELEMENT_BITS-1:0] nbr_data,
  input  logic                    shift_en,
  output logic [ELEMENT_BITS-1:0] data,
  output logic                    hit
);

  localparam logic [IW-1:0] POS_W = IW'(POS);

  logic [ELEMENT_BITS-1:0] data_r;
  logic                    hit_r;
  logic                    hit_nxt;
  logic                    active;

  assign active = POS_W < cnt;

  always_comb begin
    unique case (ctl.op)
      OP_APPEND: hit_nxt = (POS_W == cnt);
      OP_READ,
      OP_RM_IDX: hit_nxt = active && (POS_W == idx);
      OP_RM_VAL: hit_nxt = active && (data_r == key);
      default:   hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.match) begin
      hit_r <= hit_nxt;
    end
    if (ctl.exec) begin
      if (ctl.op == OP_APPEND) begin
        if (hit_r) begin
          data_r <= key;
        end
      end else if (ctl.op != OP_READ) begin
        if (shift_en) begin
          data_r <= nbr_data;
        end
      end
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

>>> hw/rtl/compacting_element_list_top.sv
// top level of the compacting element list: request control, cell row and result register
// all cells compare in the match state, then the cells shift and the result is registered
// in the exec state, where a new request can also be accepted as the result is written
// the exec state stalls while the result register is full and not being taken
// reset clears the fill count, the control state and the result valid; cell contents
// stay undefined until written
`timescale 1ns / 1ps

module compacting_element_list_top import cel_pkg::*; #(
  parameter int DEPTH        = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int IW       = (CNT_BITS > 6) ? CNT_BITS : 6;
  localparam int VW       = (ELEMENT_BITS > 32) ? ELEMENT_BITS : 32;
  localparam int CW       = (IW > 7) ? IW : 7;

  state_t                  state_r, state_nxt;
  op_t                     op_r;
  logic [ELEMENT_BITS-1:0] key_r;
  logic [IW-1:0]           idx_r;
  logic [IW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r;
  rsp_t                    out_r, out_nxt;

  logic                    accept;
  logic                    go;
  logic [VW-1:0]           val_ext;
  logic [VW-1:0]           sel_ext;
  logic [CW-1:0]           cnt_ext;
  cell_ctl_t               ctl;

  logic [ELEMENT_BITS-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]        cell_hit;
  logic [DEPTH-1:0]        pre;
  logic [ELEMENT_BITS-1:0] sel_data;
  logic                    found;

  assign go       = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) || go;
  assign accept   = in_valid && in_ready;
  assign val_ext  = VW'(in_data.value);

  assign ctl.op    = op_r;
  assign ctl.match = (state_r == S_MATCH);
  assign ctl.exec  = go;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign pre[g] = cell_hit[g];
      end else begin : g_rest
        assign pre[g] = pre[g-1] | cell_hit[g];
      end
      cel_cell #(
        .ELEMENT_BITS(ELEMENT_BITS),
        .IW          (IW),
        .POS         (g)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .key     (key_r),
        .idx     (idx_r),
        .cnt     (cnt_r),
        .nbr_data(cell_data[(g == DEPTH - 1) ? g : g + 1]),
        .shift_en(pre[g]),
        .data    (cell_data[g]),
        .hit     (cell_hit[g])
      );
    end
  endgenerate

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_hit[i] && ((i == 0) || !pre[(i == 0) ? 0 : i - 1])) begin
        sel_data = sel_data | cell_data[i];
      end
    end
  end

  assign found   = pre[DEPTH-1];
  assign sel_ext = VW'(sel_data);

  always_comb begin
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_nxt.data  = sel_ext[31:0];
    unique case (op_r)
      OP_APPEND: begin
        out_nxt.data = '0;
        if (found) begin
          out_nxt.status = ST_OK;
          cnt_nxt        = cnt_r + IW'(1);
        end else begin
          out_nxt.status = ST_FULL;
        end
      end
      OP_READ: begin
        out_nxt.status = found ? ST_OK : ST_RANGE;
      end
      OP_RM_IDX: begin
        if (found) begin
          out_nxt.status = ST_OK;
          cnt_nxt        = cnt_r - IW'(1);
        end else begin
          out_nxt.status = ST_RANGE;
        end
      end
      OP_RM_VAL: begin
        if (found) begin
          out_nxt.status = ST_OK;
          cnt_nxt        = cnt_r - IW'(1);
        end else begin
          out_nxt.status = ST_NOT_FOUND;
        end
      end
      default: out_nxt.status = ST_OK;
    endcase
    cnt_ext       = CW'(cnt_nxt);
    out_nxt.count = cnt_ext[6:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MATCH;
      S_MATCH: state_nxt = S_EXEC;
      S_EXEC: begin
        if (go) begin
          state_nxt = accept ? S_MATCH : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.func;
      key_r <= val_ext[ELEMENT_BITS-1:0];
      idx_r <= IW'(in_data.index);
    end
    if (go) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> bench/compacting_element_list_top_tb.sv
// testbench for the compacting element list: shadow list, random requests and result checks
`timescale 1ns / 1ps

module compacting_element_list_top_tb;
  import cel_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1730;
  localparam int CALM_ITEMS   = 250;
  localparam int SEGMENT_LEN  = 60;

  typedef enum int {
    MIX_FILL  = 0,
    MIX_DRAIN = 1,
    MIX_EVEN  = 2
  } mix_t;

  class list_shadow;
    logic [31:0] cells [LIST_DEPTH];
    int          fill;
    rsp_t        awaited_rsp [$];
    int          mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void close_gap(int pos);
      for (int j = pos + 1; j < fill; j++) begin
        cells[j - 1] = cells[j];
      end
      fill--;
    endfunction

    task apply_request(req_t r);
      rsp_t want;
      int   pos;
      want.status = ST_OK;
      want.data   = '0;
      case (r.func)
        OP_APPEND: begin
          if (fill >= LIST_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            cells[fill] = r.value;
            fill++;
          end
        end
        OP_READ: begin
          if (int'(r.index) >= fill) begin
            want.status = ST_RANGE;
          end else begin
            want.data = cells[r.index];
          end
        end
        OP_RM_IDX: begin
          if (int'(r.index) >= fill) begin
            want.status = ST_RANGE;
          end else begin
            want.data = cells[r.index];
            close_gap(r.index);
          end
        end
        default: begin
          pos = -1;
          for (int i = 0; i < fill; i++) begin
            if (pos < 0 && cells[i] == r.value) begin
              pos = i;
            end
          end
          if (pos < 0) begin
            want.status = ST_NOT_FOUND;
          end else begin
            want.data = cells[pos];
            close_gap(pos);
          end
        end
      endcase
      want.count = 7'(fill);
      awaited_rsp.push_back(want);
    endtask

    task compare_response(rsp_t got);
      rsp_t want;
      if (awaited_rsp.size() == 0) begin
        report($sformatf("result with nothing awaited: %p", got));
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status) begin
        report($sformatf("status %0d, wanted %s", got.status, want.status.name()));
      end
      if (got.data !== want.data) begin
        report($sformatf("data %h, wanted %h", got.data, want.data));
      end
      if (got.count !== want.count) begin
        report($sformatf("count %0d, wanted %0d", got.count, want.count));
      end
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  list_shadow sb;
  bit         idle_on    = 1'b1;
  int         stall_left = 0;

  compacting_element_list_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic req_t mk(op_t f, logic [31:0] v, logic [5:0] x);
    req_t r;
    r.func  = f;
    r.value = v;
    r.index = x;
    return r;
  endfunction

  function automatic req_t random_request(mix_t mix);
    req_t r;
    int   n;
    int   roll;
    int   a_lim;
    int   r_lim;
    int   x_lim;
    n    = sb.fill;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        a_lim = 75; r_lim = 85; x_lim = 93;
      end
      MIX_DRAIN: begin
        a_lim = 15; r_lim = 35; x_lim = 70;
      end
      default: begin
        a_lim = 40; r_lim = 65; x_lim = 82;
      end
    endcase
    if (roll < a_lim) begin
      r.func = OP_APPEND;
    end else if (roll < r_lim) begin
      r.func = OP_READ;
    end else if (roll < x_lim) begin
      r.func = OP_RM_IDX;
    end else begin
      r.func = OP_RM_VAL;
    end
    case ($urandom_range(0, 3))
      0:       r.value = 32'($urandom_range(0, 7));
      1:       r.value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: r.value = $urandom;
    endcase
    if (r.func == OP_RM_VAL && n > 0 && $urandom_range(0, 2) != 0) begin
      r.value = sb.cells[$urandom_range(0, n - 1)];
    end
    if (n > 0 && $urandom_range(0, 3) != 0) begin
      r.index = 6'($urandom_range(0, n - 1));
    end else begin
      r.index = 6'($urandom_range(0, 63));
    end
    return r;
  endfunction

  task send_item(req_t r);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_request(r);
  endtask

  // sender stays quiet until every awaited result is back
  task hold_off();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.compare_response(out_data);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    req_t plan [$];
    mix_t mix;
    sb  = new();
    mix = MIX_FILL;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, duplicates, first-match removal, out of range at both ends
    plan.push_back(mk(OP_READ,   32'h0,         6'd0));
    plan.push_back(mk(OP_RM_IDX, 32'h0,         6'd0));
    plan.push_back(mk(OP_RM_VAL, 32'h0,         6'd0));
    plan.push_back(mk(OP_APPEND, 32'h0,         6'd63));
    plan.push_back(mk(OP_APPEND, 32'hFFFF_FFFF, 6'd0));
    plan.push_back(mk(OP_APPEND, 32'hA5A5_A5A5, 6'd21));
    plan.push_back(mk(OP_APPEND, 32'hFFFF_FFFF, 6'd42));
    plan.push_back(mk(OP_READ,   32'hFFFF_FFFF, 6'd0));
    plan.push_back(mk(OP_READ,   32'h0,         6'd1));
    plan.push_back(mk(OP_READ,   32'h0,         6'd3));
    plan.push_back(mk(OP_READ,   32'h0,         6'd4));
    plan.push_back(mk(OP_READ,   32'h0,         6'd63));
    plan.push_back(mk(OP_RM_VAL, 32'hFFFF_FFFF, 6'd63));
    plan.push_back(mk(OP_READ,   32'h0,         6'd1));
    plan.push_back(mk(OP_RM_VAL, 32'h1234_5678, 6'd0));
    plan.push_back(mk(OP_RM_IDX, 32'h0,         6'd2));
    plan.push_back(mk(OP_RM_IDX, 32'hFFFF_FFFF, 6'd63));
    plan.push_back(mk(OP_RM_IDX, 32'h0,         6'd0));
    plan.push_back(mk(OP_RM_VAL, 32'hA5A5_A5A5, 6'd0));
    plan.push_back(mk(OP_READ,   32'h0,         6'd0));
    plan.push_back(mk(OP_RM_IDX, 32'h0,         6'd0));
    foreach (plan[k]) begin
      send_item(plan[k]);
    end
    hold_off();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT_LEN == 0 && i != 0) begin
        mix = mix_t'($urandom_range(0, 2));
      end
      if (i == RANDOM_ITEMS / 2) begin
        hold_off();
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        idle_on = 1'b0;
      end
      send_item(random_request(mix));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (out_valid) begin
      sb.report("result still pending after the last one awaited");
    end
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d results still awaited", sb.awaited_rsp.size());
    $display("Verification failed");
    $finish;
  end

endmodule
